FILE: rtl/core/sorted_insert_queue_core_macros.svh
// assertion macros used by siq_store in the sorted insert queue rtl
// no dependencies; taken in by `include in the files that assert
`ifndef SORTED_INSERT_QUEUE_CORE_MACROS_SVH
`define SORTED_INSERT_QUEUE_CORE_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define SIQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, also during reset
`define SIQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/siq_pkg.sv
// command and status codes and the beat structs of the sorted insert queue
// no dependencies; used by siq_store and sorted_insert_queue_core
`default_nettype none

package siq_pkg;

  localparam logic [1:0] CMD_SORTED = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int KeyW = 8;
  localparam int PayW = 32;
  localparam int OccW = 5;

  typedef struct packed {
    logic            valid;
    logic [1:0]      cmd;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } siq_op_t;

  typedef struct packed {
    logic            is_empty;
    logic [OccW-1:0] occupancy;
    logic [PayW-1:0] front_payload;
    logic [KeyW-1:0] front_key;
    logic [1:0]      status;
  } siq_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_insert_queue_core.sv
// top level of the sorted insert queue: stream ports, input and result registers
// depends on siq_pkg and siq_store
//
// usage
//   s_axis carries one command beat: sorted insert, append at rear or remove front.
//   m_axis returns one result beat per command: status, front entry, occupancy
//   and an empty flag, in command order.
//   a sorted insert goes ahead of the first held entry whose key is not smaller.
//   from input beat to result beat the command is registered in the input
//   register, then compared against all cells, placed and shifted while the
//   result register loads.
//   throughput is one beat per cycle while m_axis_tready is high; the
//   combinational compare and shift over every cell sets the clock limit.
//   when m_axis_tready is low the result register holds its beat and the
//   input register holds the next command; s_axis_tready falls once both
//   are full and rises in the cycle the result is taken.
//   reset empties the queue and clears both valid flags; cell contents are
//   left as they are and never read before written.
`default_nettype none

module sorted_insert_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // command[1:0], key[9:2], payload[41:10], zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // status, front_key, front_payload, occupancy, is_empty
);

  siq_pkg::siq_op_t  in_q, op;
  siq_pkg::siq_res_t res, out_q;
  logic              out_vld_q;
  logic              adv;

  assign adv           = in_q.valid && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_q.valid || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (s_axis_tready) begin
      in_q.valid <= s_axis_tvalid;
      if (s_axis_tvalid) begin
        in_q.cmd     <= s_axis_tdata[1:0];
        in_q.key     <= s_axis_tdata[9:2];
        in_q.payload <= s_axis_tdata[41:10];
      end
    end
  end

  always_comb begin
    op       = in_q;
    op.valid = adv;
  end

  siq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/siq_store.sv
// entry cells of the sorted insert queue with parallel key compare and shift
// depends on siq_pkg and sorted_insert_queue_core_macros.svh
`default_nettype none

`include "sorted_insert_queue_core_macros.svh"

module siq_store #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire siq_pkg::siq_op_t  op_i,
  output siq_pkg::siq_res_t      res_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [siq_pkg::KeyW-1:0] key_q     [QUEUE_DEPTH];
  logic [siq_pkg::KeyW-1:0] key_d     [QUEUE_DEPTH];
  logic [siq_pkg::PayW-1:0] payload_q [QUEUE_DEPTH];
  logic [siq_pkg::PayW-1:0] payload_d [QUEUE_DEPTH];
  logic [CntW-1:0]          count_q, count_d;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] prior;
  logic                   full, empty, is_ins, is_rem, ins_ok, rem_ok;
  logic                   is_append;

  assign full      = (count_q == CntW'(QUEUE_DEPTH));
  assign empty     = (count_q == '0);
  assign is_append = (op_i.cmd == siq_pkg::CMD_APPEND);
  assign is_ins    = (op_i.cmd == siq_pkg::CMD_SORTED) || is_append;
  assign is_rem    = (op_i.cmd == siq_pkg::CMD_REMOVE);
  assign ins_ok    = op_i.valid && is_ins && !full;
  assign rem_ok    = op_i.valid && is_rem && !empty;

  // every occupied cell whose key is not smaller; prior picks the first
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CntW'(i) < count_q) && (key_q[i] >= op_i.key);
    end
  end

  assign prior[0] = 1'b0;
  for (genvar i = 1; i < QUEUE_DEPTH; i++) begin : g_prefix
    assign prior[i] = prior[i-1] | match[i-1];
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [siq_pkg::KeyW-1:0] prev_key, next_key;
    logic [siq_pkg::PayW-1:0] prev_pay, next_pay;
    logic                     at_rear, hit;

    if (i == 0) begin : g_first
      assign prev_key = op_i.key;
      assign prev_pay = op_i.payload;
    end else begin : g_mid
      assign prev_key = key_q[i-1];
      assign prev_pay = payload_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_key = key_q[i];
      assign next_pay = payload_q[i];
    end else begin : g_inner
      assign next_key = key_q[i+1];
      assign next_pay = payload_q[i+1];
    end

    assign at_rear = (CntW'(i) == count_q);
    assign hit     = (match[i] && !prior[i]) || (at_rear && !prior[i]);

    always_comb begin
      key_d[i]     = key_q[i];
      payload_d[i] = payload_q[i];
      if (ins_ok) begin
        if (is_append) begin
          if (at_rear) begin
            key_d[i]     = op_i.key;
            payload_d[i] = op_i.payload;
          end
        end else if (prior[i]) begin
          key_d[i]     = prev_key;
          payload_d[i] = prev_pay;
        end else if (hit) begin
          key_d[i]     = op_i.key;
          payload_d[i] = op_i.payload;
        end
      end else if (rem_ok) begin
        key_d[i]     = next_key;
        payload_d[i] = next_pay;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_o.status = siq_pkg::ST_DONE;
    if (is_ins && full) begin
      res_o.status = siq_pkg::ST_FULL;
    end else if (is_rem && empty) begin
      res_o.status = siq_pkg::ST_EMPTY;
    end
    if (rem_ok) begin
      res_o.front_key     = key_q[0];
      res_o.front_payload = payload_q[0];
    end else if (count_d == '0) begin
      res_o.front_key     = '0;
      res_o.front_payload = '0;
    end else begin
      res_o.front_key     = key_d[0];
      res_o.front_payload = payload_d[0];
    end
    res_o.occupancy = siq_pkg::OccW'(count_d);
    res_o.is_empty  = (count_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      key_q     <= key_d;
      payload_q <= payload_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (op_i.valid) begin
      count_q <= count_d;
    end
  end

  `SIQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QUEUE_DEPTH), "count over depth")
  `SIQ_ASSERT(a_full_refuse, clk_i, rst_ni, op_i.valid && is_ins && full |=> full, "full insert")
  `SIQ_ASSERT(a_ins_grow, clk_i, rst_ni, ins_ok |=> count_q == $past(count_q) + CntW'(1), "no grow")
  `SIQ_ASSERT(a_rem_shrink, clk_i, rst_ni, rem_ok |=> count_q == $past(count_q) - CntW'(1), "no shrink")

endmodule

`default_nettype wire

FILE: sim/sorted_insert_queue_core_tb.sv
// self-checking testbench for sorted_insert_queue_core: random stream traffic on both sides
// depends on siq_pkg and the sorted_insert_queue_core rtl; a scoreboard class predicts each result
`default_nettype none

module sorted_insert_queue_core_tb;
  import siq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIRECTED_APPENDS = 11;
  localparam int RANDOM_ITEMS = 1528;

  class siq_scoreboard;
    logic [KeyW-1:0] held_keys[$];
    logic [PayW-1:0] held_pays[$];
    siq_res_t expected_results[$];
    int fail_count;
    int n_beats;
    int n_refused;
    int n_empty_removes;
    int peak_occ;

    function int pending();
      return expected_results.size();
    endfunction

    // queue update and result for one accepted command beat
    function void note_command(logic [1:0] cmd, logic [KeyW-1:0] key, logic [PayW-1:0] pay);
      siq_res_t res;
      int pos;
      bit removed;
      res = '0;
      removed = 0;
      n_beats++;
      case (cmd)
        CMD_SORTED, CMD_APPEND: begin
          if (held_keys.size() >= QDEPTH) begin
            res.status = ST_FULL;
            n_refused++;
          end else begin
            pos = held_keys.size();
            if (cmd == CMD_SORTED) begin
              for (int i = 0; i < held_keys.size(); i++) begin
                if (held_keys[i] >= key) begin
                  pos = i;
                  break;
                end
              end
            end
            held_keys.insert(pos, key);
            held_pays.insert(pos, pay);
          end
        end
        CMD_REMOVE: begin
          if (held_keys.size() == 0) begin
            res.status = ST_EMPTY;
            n_empty_removes++;
          end else begin
            res.front_key = held_keys.pop_front();
            res.front_payload = held_pays.pop_front();
            removed = 1;
          end
        end
        default: ;
      endcase
      if (!removed && held_keys.size() > 0) begin
        res.front_key = held_keys[0];
        res.front_payload = held_pays[0];
      end
      res.occupancy = OccW'(held_keys.size());
      res.is_empty = (held_keys.size() == 0);
      if (held_keys.size() > peak_occ) peak_occ = held_keys.size();
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [47:0] beat);
      siq_res_t got;
      siq_res_t exp;
      got = beat;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", beat);
        fail_count++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        fail_count++;
      end
      if (got.front_key !== exp.front_key) begin
        $error("front_key: expected %0h, got %0h", exp.front_key, got.front_key);
        fail_count++;
      end
      if (got.front_payload !== exp.front_payload) begin
        $error("front_payload: expected %0h, got %0h", exp.front_payload, got.front_payload);
        fail_count++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        fail_count++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %0b, got %0b", exp.is_empty, got.is_empty);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  siq_scoreboard sb = new();
  int cycle_count = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_stall = 0;

  sorted_insert_queue_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),  // command[1:0], key[9:2], payload[41:10], zero
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)   // status, front_key, front_payload, occupancy, is_empty
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (rx_calm > 0) begin
      rx_calm--;
      m_axis_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(99) < 3) rx_calm = $urandom_range(30, 100);
      else if ($urandom_range(99) < 35) rx_stall = idle_len();
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                           input logic [PayW-1:0] pay);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(99) < 2) tx_calm = $urandom_range(30, 100);
      gap = idle_len();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, pay, key, cmd};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    sb.note_command(cmd, key, pay);
  endtask

  task automatic run_random();
    int sent;
    int block_len;
    int insert_pct;
    bit narrow_keys;
    logic [1:0] cmd;
    logic [KeyW-1:0] key;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // each block leans toward filling, draining or balance
      case ($urandom_range(3))
        0: insert_pct = 15;
        1: insert_pct = 50;
        2: insert_pct = 80;
        default: insert_pct = 95;
      endcase
      narrow_keys = $urandom_range(1);
      block_len = $urandom_range(20, 60);
      for (int i = 0; i < block_len && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(99) < 3) begin
          cmd = CMD_IGNORED;
        end else begin
          sent++;
          if ($urandom_range(99) < insert_pct)
            cmd = ($urandom_range(99) < 70) ? CMD_SORTED : CMD_APPEND;
          else
            cmd = CMD_REMOVE;
        end
        if (narrow_keys) key = KeyW'($urandom_range(3) * 85);
        else key = KeyW'($urandom_range(255));
        send_beat(cmd, key, $urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, extremes of key and payload, equal keys, fill to full
    send_beat(CMD_REMOVE, 8'hff, '1);
    send_beat(CMD_IGNORED, 8'h00, '0);
    send_beat(CMD_SORTED, 8'h80, '1);
    send_beat(CMD_SORTED, 8'h00, '0);
    send_beat(CMD_SORTED, 8'hff, 32'h5555_aaaa);
    send_beat(CMD_SORTED, 8'h80, 32'haaaa_5555);
    send_beat(CMD_APPEND, 8'h00, $urandom);
    for (int i = 0; i < DIRECTED_APPENDS; i++)
      send_beat(CMD_APPEND, KeyW'(i * 23), $urandom);
    send_beat(CMD_SORTED, 8'h00, $urandom);
    send_beat(CMD_APPEND, 8'hff, $urandom);
    send_beat(CMD_IGNORED, 8'h5a, $urandom);
    send_beat(CMD_REMOVE, 8'h00, '0);

    run_random();
    s_axis_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run: %0d command beats, %0d inserts refused on full, %0d removes on empty",
             sb.n_beats, sb.n_refused, sb.n_empty_removes);
    $display("peak occupancy %0d of %0d, %0d field mismatches",
             sb.peak_occ, QDEPTH, sb.fail_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
